// ----- rtl/oafd_pkg.sv -----
// Shared types, constants and the arc tangent table of the opening angle unit.
`timescale 1ns / 1ps
package oafd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int SQRT_N        = 31;
  localparam int PIPE_LEN      = 2 * CORDIC_N + SQRT_N + 9;

  localparam int DATA_W = 34;
  localparam int CS_W   = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 66;
  localparam int SQ_W   = 62;
  localparam int ANG_W  = 16;
  localparam int REM_W  = 14;
  localparam int OUT_W  = 15;
  localparam int ZP_W   = 48;
  localparam int OM_W   = 62;
  localparam int FRAC   = 30;
  localparam int RND_SH = 46;

  localparam logic [ANG_W-1:0] FULL_TURN = 16'd36000;
  localparam logic [ANG_W-1:0] QUARTER_1 = 16'd9000;
  localparam logic [ANG_W-1:0] QUARTER_2 = 16'd18000;
  localparam logic [ANG_W-1:0] QUARTER_3 = 16'd27000;

  localparam logic signed [DATA_W-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [DATA_W-1:0] PI_HALF  = 34'sd1686629713;
  localparam logic signed [DATA_W-1:0] PI_Q30   = 34'sd3373259426;
  localparam logic signed [SUM_W-1:0]  ONE_POS  = 66'sd1073741824;
  localparam logic signed [SUM_W-1:0]  ONE_NEG  = -66'sd1073741824;
  localparam logic [SQ_W-1:0]          ONE_SQ   = 62'd1 << 60;
  localparam logic [5:0]               SQRT_TOP = 6'd60;

  localparam logic [ZP_W-1:0] RAD_PER_CDEG = 48'd12281662764;
  localparam logic [ZP_W-1:0] ZP_HALF      = 48'd1 << 45;
  localparam logic [OM_W-1:0] CDEG_PER_RAD = 62'd375493621;
  localparam logic [OM_W-1:0] OM_HALF      = 62'd1 << 45;
  localparam logic [OUT_W-1:0] MAX_ANGLE   = 15'd18000;

  localparam int LANE_POLAR_A   = 0;
  localparam int LANE_AZIMUTH_A = 1;
  localparam int LANE_POLAR_B   = 2;
  localparam int LANE_AZIMUTH_B = 3;

  typedef enum logic {
    CORDIC_ROTATE = 1'b0,
    CORDIC_VECTOR = 1'b1
  } cordic_mode_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  function automatic logic signed [DATA_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [DATA_W-1:0] a;
    case (idx)
      5'd0:  a = 34'sd843314856;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043836;
      5'd3:  a = 34'sd133525158;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543515;
      5'd6:  a = 34'sd16775850;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194282;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048575;
      5'd11: a = 34'sd524287;
      5'd12: a = 34'sd262143;
      5'd13: a = 34'sd131071;
      5'd14: a = 34'sd65535;
      5'd15: a = 34'sd32767;
      5'd16: a = 34'sd16383;
      5'd17: a = 34'sd8191;
      5'd18: a = 34'sd4095;
      5'd19: a = 34'sd2047;
      5'd20: a = 34'sd1023;
      5'd21: a = 34'sd511;
      5'd22: a = 34'sd255;
      5'd23: a = 34'sd127;
      5'd24: a = 34'sd63;
      5'd25: a = 34'sd31;
      5'd26: a = 34'sd15;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/oafd_cordic_cell.sv -----
// One CORDIC micro-rotation with its output register.
`timescale 1ns / 1ps
module oafd_cordic_cell (
  input  logic                 clk,
  input  logic                 en,
  input  oafd_pkg::cordic_mode_t mode,
  input  logic [4:0]           shift,
  input  oafd_pkg::cordic_vec_t  din,
  output oafd_pkg::cordic_vec_t  dout
);
  import oafd_pkg::*;

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic signed [DATA_W-1:0] ang;
  logic                     dir_pos;
  cordic_vec_t              nxt;

  always_comb begin
    xs      = din.x >>> shift;
    ys      = din.y >>> shift;
    ang     = atan_q30(shift);
    dir_pos = (mode == CORDIC_VECTOR) ? din.y[DATA_W-1] : !din.z[DATA_W-1];
    if (dir_pos) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ang;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/oafd_cordic_chain.sv -----
// Row of CORDIC cells, one micro-rotation per cell.
`timescale 1ns / 1ps
module oafd_cordic_chain (
  input  logic                  clk,
  input  logic                  en,
  input  oafd_pkg::cordic_mode_t mode,
  input  oafd_pkg::cordic_vec_t  din,
  output oafd_pkg::cordic_vec_t  dout
);
  import oafd_pkg::*;

  cordic_vec_t link [CORDIC_N+1];

  assign link[0] = din;

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cell
    oafd_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .mode (mode),
      .shift(5'(g)),
      .din  (link[g]),
      .dout (link[g+1])
    );
  end

  assign dout = link[CORDIC_N];

endmodule

// ----- rtl/oafd_sqrt_cell.sv -----
// One digit step of the integer square root with its output register.
`timescale 1ns / 1ps
module oafd_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      step,
  input  oafd_pkg::sqrt_t din,
  output oafd_pkg::sqrt_t dout
);
  import oafd_pkg::*;

  logic [5:0]      pos;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  sqrt_t           nxt;

  always_comb begin
    pos   = SQRT_TOP - {step, 1'b0};
    bitv  = SQ_W'(1) << pos;
    trial = din.root + bitv;
    if (din.rem >= trial) begin
      nxt.rem  = din.rem - trial;
      nxt.root = (din.root >> 1) + bitv;
    end else begin
      nxt.rem  = din.rem;
      nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/opening_angle_from_directions_unit.sv -----
// Top level: opening angle between two track directions.
`timescale 1ns / 1ps
// Takes one pair of directions (polar and azimuth angles in 0.01 degree) per clock while
// pair_stall is low and returns the angle between them in 0.01 degree, 0 to 18000, one result
// per pair, in order. The datapath holds two rows of CORDIC cells (sine/cosine, arc cosine)
// and a 31-cell square-root row. The dot product is clamped to [-1, 1] before the arc
// cosine, and identical pairs give zero. An output register with a one-entry skid buffer
// lets a new pair in while a result waits; pair_stall rises only when that buffer is full.
module opening_angle_from_directions_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        pair_valid,
  output logic        pair_stall,
  input  logic [14:0] polar_a,
  input  logic [15:0] azimuth_a,
  input  logic [14:0] polar_b,
  input  logic [15:0] azimuth_b,
  output logic        angle_valid,
  input  logic        angle_stall,
  output logic [14:0] opening_angle
);
  import oafd_pkg::*;

  logic adv;
  logic skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic [PIPE_LEN-1:0] vld;
  logic [PIPE_LEN-1:0] eqf;

  assign adv        = !skid_valid;
  assign pair_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LEN-2:0], pair_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eqf <= {eqf[PIPE_LEN-2:0], (polar_a == polar_b) && (azimuth_a == azimuth_b)};
    end
  end

  // sine and cosine lanes
  logic [ANG_W-1:0]         ang_in  [4];
  quad_t                    q1      [4];
  logic [REM_W-1:0]         r1      [4];
  logic signed [DATA_W-1:0] z2      [4];
  quad_t                    qd      [4][CORDIC_N+1];
  cordic_vec_t              rot_in  [4];
  cordic_vec_t              rot_out [4];
  logic signed [CS_W-1:0]   cs_cos  [4];
  logic signed [CS_W-1:0]   cs_sin  [4];

  assign ang_in[LANE_POLAR_A]   = {1'b0, polar_a};
  assign ang_in[LANE_AZIMUTH_A] = azimuth_a;
  assign ang_in[LANE_POLAR_B]   = {1'b0, polar_b};
  assign ang_in[LANE_AZIMUTH_B] = azimuth_b;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [ANG_W-1:0] red;
    quad_t            q_c;
    logic [REM_W-1:0] r_c;
    logic [ZP_W-1:0]  zp;
    logic signed [DATA_W-1:0] c_m;
    logic signed [DATA_W-1:0] s_m;

    always_comb begin
      red = (ang_in[l] >= FULL_TURN) ? ang_in[l] - FULL_TURN : ang_in[l];
      if (red >= QUARTER_3) begin
        q_c = QUAD_3;
        r_c = REM_W'(red - QUARTER_3);
      end else if (red >= QUARTER_2) begin
        q_c = QUAD_2;
        r_c = REM_W'(red - QUARTER_2);
      end else if (red >= QUARTER_1) begin
        q_c = QUAD_1;
        r_c = REM_W'(red - QUARTER_1);
      end else begin
        q_c = QUAD_0;
        r_c = REM_W'(red);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q1[l] <= q_c;
        r1[l] <= r_c;
      end
    end

    assign zp = ZP_W'(r1[l]) * RAD_PER_CDEG + ZP_HALF;

    always_ff @(posedge clk) begin
      if (adv) begin
        z2[l]    <= DATA_W'(zp >> RND_SH);
        qd[l][0] <= q1[l];
        for (int k = 1; k <= CORDIC_N; k++) begin
          qd[l][k] <= qd[l][k-1];
        end
      end
    end

    assign rot_in[l] = '{x: GAIN_INV, y: '0, z: z2[l]};

    oafd_cordic_chain u_rot (
      .clk (clk),
      .en  (adv),
      .mode(CORDIC_ROTATE),
      .din (rot_in[l]),
      .dout(rot_out[l])
    );

    always_comb begin
      case (qd[l][CORDIC_N])
        QUAD_0: begin
          c_m = rot_out[l].x;
          s_m = rot_out[l].y;
        end
        QUAD_1: begin
          c_m = -rot_out[l].y;
          s_m = rot_out[l].x;
        end
        QUAD_2: begin
          c_m = -rot_out[l].x;
          s_m = -rot_out[l].y;
        end
        default: begin
          c_m = rot_out[l].y;
          s_m = -rot_out[l].x;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs_cos[l] <= CS_W'(c_m);
        cs_sin[l] <= CS_W'(s_m);
      end
    end
  end

  // dot product
  logic signed [PROD_W-1:0] p_xa, p_ya, p_xb, p_yb, p_zz;
  logic signed [PROD_W-1:0] m_x, m_y, m_z;
  logic signed [CS_W-1:0]   xa, ya, xb, yb;
  logic signed [SUM_W-1:0]  dsum, dsh, dclip;
  logic signed [CS_W-1:0]   dot;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xa <= cs_sin[LANE_POLAR_A] * cs_cos[LANE_AZIMUTH_A];
      p_ya <= cs_sin[LANE_POLAR_A] * cs_sin[LANE_AZIMUTH_A];
      p_xb <= cs_sin[LANE_POLAR_B] * cs_cos[LANE_AZIMUTH_B];
      p_yb <= cs_sin[LANE_POLAR_B] * cs_sin[LANE_AZIMUTH_B];
      p_zz <= cs_cos[LANE_POLAR_A] * cs_cos[LANE_POLAR_B];
    end
  end

  assign xa = CS_W'(p_xa >>> FRAC);
  assign ya = CS_W'(p_ya >>> FRAC);
  assign xb = CS_W'(p_xb >>> FRAC);
  assign yb = CS_W'(p_yb >>> FRAC);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_x <= xa * xb;
      m_y <= ya * yb;
      m_z <= p_zz;
    end
  end

  always_comb begin
    dsum = SUM_W'(m_x) + SUM_W'(m_y) + SUM_W'(m_z);
    dsh  = dsum >>> FRAC;
    if (dsh > ONE_POS) begin
      dclip = ONE_POS;
    end else if (dsh < ONE_NEG) begin
      dclip = ONE_NEG;
    end else begin
      dclip = dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot <= CS_W'(dclip);
    end
  end

  // sine of the opening angle by square root
  logic signed [PROD_W-1:0] csq;
  logic signed [CS_W-1:0]   cd [SQRT_N+1];
  sqrt_t                    sq_link [SQRT_N+1];

  assign csq = dot * dot;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_link[0].rem  <= ONE_SQ - SQ_W'(csq);
      sq_link[0].root <= '0;
      cd[0]           <= dot;
      for (int k = 1; k <= SQRT_N; k++) begin
        cd[k] <= cd[k-1];
      end
    end
  end

  for (genvar g = 0; g < SQRT_N; g++) begin : g_sqrt
    oafd_sqrt_cell u_sq (
      .clk (clk),
      .en  (adv),
      .step(5'(g)),
      .din (sq_link[g]),
      .dout(sq_link[g+1])
    );
  end

  // arc cosine
  cordic_vec_t vec_in;
  cordic_vec_t vec_out;
  logic signed [CS_W-1:0] c_f;
  logic signed [DATA_W-1:0] s_f;

  assign c_f = cd[SQRT_N];
  assign s_f = DATA_W'(sq_link[SQRT_N].root);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_f[CS_W-1]) begin
        vec_in.x <= s_f;
        vec_in.y <= -DATA_W'(c_f);
        vec_in.z <= PI_HALF;
      end else begin
        vec_in.x <= DATA_W'(c_f);
        vec_in.y <= s_f;
        vec_in.z <= '0;
      end
    end
  end

  oafd_cordic_chain u_vec (
    .clk (clk),
    .en  (adv),
    .mode(CORDIC_VECTOR),
    .din (vec_in),
    .dout(vec_out)
  );

  // radians to 0.01 degree
  logic signed [DATA_W-1:0] zc;
  logic [OM_W-1:0]          om_prod;
  logic [OM_W-1:0]          om_rnd;
  logic [OUT_W-1:0]         res;

  always_comb begin
    if (vec_out.z[DATA_W-1]) begin
      zc = '0;
    end else if (vec_out.z > PI_Q30) begin
      zc = PI_Q30;
    end else begin
      zc = vec_out.z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      om_prod <= OM_W'(zc[31:0]) * CDEG_PER_RAD;
    end
  end

  always_comb begin
    om_rnd = (om_prod + OM_HALF) >> RND_SH;
    if (eqf[PIPE_LEN-1]) begin
      res = '0;
    end else if (om_rnd > OM_W'(MAX_ANGLE)) begin
      res = MAX_ANGLE;
    end else begin
      res = OUT_W'(om_rnd);
    end
  end

  // output register and skid buffer
  logic push;
  logic take;

  assign push = adv && vld[PIPE_LEN-1];
  assign take = angle_valid && !angle_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!angle_valid || take) begin
      if (skid_valid) begin
        angle_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        angle_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!angle_valid || take) begin
      if (skid_valid) begin
        opening_angle <= skid_data;
      end else if (push) begin
        opening_angle <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

endmodule

// ----- rtl/oafd_checker.sv -----
// Port checker for the opening angle unit, bound to the top level.
`timescale 1ns / 1ps
module oafd_checker (
  input logic        clk,
  input logic        rst,
  input logic        pair_stall,
  input logic        angle_valid,
  input logic        angle_stall,
  input logic [14:0] opening_angle
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle_stall |=> angle_valid && $stable(opening_angle))
    else $error("stalled result changed or vanished");

  a_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> opening_angle <= 15'd18000)
    else $error("opening angle beyond 180 degrees");

  a_reset: assert property (@(posedge clk)
    rst |=> !angle_valid && !pair_stall)
    else $error("output or skid buffer not cleared by reset");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> angle_valid)
    else $error("input held off with no result waiting");

endmodule

bind opening_angle_from_directions_unit oafd_checker u_oafd_checker (.*);

// ----- tb/opening_angle_from_directions_unit_test.sv -----
// Self-checking testbench for the opening angle unit: directed, random and back-pressure tests.
`timescale 1ns / 1ps
module opening_angle_from_directions_unit_test;
  import oafd_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 2 * PIPE_LEN + 20;

  typedef struct {
    logic [14:0] pa;
    logic [15:0] aa;
    logic [14:0] pb;
    logic [15:0] ab;
    logic [14:0] angle;
  } pair_angle_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pair_valid = 1'b0;
  logic        pair_stall;
  logic [14:0] polar_a = '0;
  logic [15:0] azimuth_a = '0;
  logic [14:0] polar_b = '0;
  logic [15:0] azimuth_b = '0;
  logic        angle_valid;
  logic        angle_stall = 1'b0;
  logic [14:0] opening_angle;

  pair_angle_t angles_due[$];
  int          mismatches = 0;
  int          pairs_sent = 0;
  int          angles_seen = 0;
  int          idle_cycles = 0;
  int          hold_cycles = 0;
  bit          no_gaps = 1'b0;

  longint atan_q30_tab[32] = '{
    843314856, 497837829, 263043836, 133525158, 67021687, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
    8, 4, 2, 1, 0};

  opening_angle_from_directions_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void cos_sin(input longint unsigned ang, output longint co,
                                  output longint si);
    longint unsigned a, r;
    longint x, y, z, t;
    quad_t q;
    a = ang % 36000;
    q = quad_t'(a / 9000);
    r = a % 9000;
    z = longint'((r * 64'd12281662764 + (64'd1 << 45)) >> 46);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q30_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q30_tab[i];
      end
      x = t;
    end
    case (q)
      QUAD_0: begin co = x; si = y; end
      QUAD_1: begin co = -y; si = x; end
      QUAD_2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [14:0] arc_cos_cdeg(input longint c);
    longint x, y, z, t;
    longint unsigned res;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    if (c < -64'sd1073741824) c = -64'sd1073741824;
    x = c;
    y = longint'(root_floor((64'd1 << 60) - longint'(c * c)));
    z = 0;
    if (x < 0) begin
      t = y;
      y = -x;
      x = t;
      z = 1686629713;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q30_tab[i];
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q30_tab[i];
      end
      x = t;
    end
    if (z < 0) z = 0;
    if (z > 64'sd3373259426) z = 64'sd3373259426;
    res = (longint'(z) * 64'd375493621 + (64'd1 << 45)) >> 46;
    if (res > 18000) res = 18000;
    return res[14:0];
  endfunction

  function automatic logic [14:0] opening_angle_of(input logic [14:0] pa, input logic [15:0] aa,
                                                   input logic [14:0] pb, input logic [15:0] ab);
    longint cta, sta, cpa, spa, ctb, stb, cpb, spb, xa, ya, xb, yb;
    if (pa == pb && aa == ab) return '0;
    cos_sin(64'(pa), cta, sta);
    cos_sin(64'(aa), cpa, spa);
    cos_sin(64'(pb), ctb, stb);
    cos_sin(64'(ab), cpb, spb);
    xa = (sta * cpa) >>> 30;
    ya = (sta * spa) >>> 30;
    xb = (stb * cpb) >>> 30;
    yb = (stb * spb) >>> 30;
    return arc_cos_cdeg((xa * xb + ya * yb + cta * ctb) >>> 30);
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pair(input logic [14:0] pa, input logic [15:0] aa,
                           input logic [14:0] pb, input logic [15:0] ab);
    pair_angle_t e;
    int g;
    pair_valid <= 1'b1;
    polar_a <= pa;
    azimuth_a <= aa;
    polar_b <= pb;
    azimuth_b <= ab;
    do @(posedge clk); while (pair_stall);
    e.pa = pa;
    e.aa = aa;
    e.pb = pb;
    e.ab = ab;
    e.angle = opening_angle_of(pa, aa, pb, ab);
    angles_due.push_back(e);
    pairs_sent++;
    g = gap_len();
    if (g > 0) begin
      pair_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // receiver stalls
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        angle_stall <= 1'b1;
      end else if (left > 0) begin
        left--;
        angle_stall <= 1'b1;
      end else begin
        left = gap_len();
        angle_stall <= (left > 0);
        if (left > 0) left--;
      end
    end
  end

  always @(posedge clk) begin
    pair_angle_t e;
    if (!rst && angle_valid && !angle_stall) begin
      angles_seen++;
      if (angles_due.size() == 0) begin
        $display("%0t: unexpected transfer, actual %0d", $time, opening_angle);
        mismatches++;
      end else begin
        e = angles_due.pop_front();
        if (opening_angle !== e.angle) begin
          $display("%0t: angle for (%0d,%0d)-(%0d,%0d): expected %0d, actual %0d", $time,
                   e.pa, e.aa, e.pb, e.ab, e.angle, opening_angle);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (angle_valid && !angle_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    send_pair(0, 0, 0, 0);
    send_pair(15'd18000, 16'd35999, 15'd18000, 16'd35999);
    send_pair(0, 0, 15'd18000, 0);
    send_pair(15'd9000, 0, 15'd9000, 16'd18000);
    send_pair(15'd9000, 0, 15'd9000, 16'd9000);
    send_pair(15'd9000, 16'd27000, 15'd9000, 16'd9000);
    send_pair(15'd4500, 16'd1000, 15'd4500, 16'd1001);
    send_pair(15'd100, 16'd200, 15'd101, 16'd200);
    send_pair(15'd17999, 0, 15'd1, 16'd18000);
    send_pair(15'h7fff, 16'hffff, 0, 0);
    send_pair(0, 0, 15'h7fff, 16'hffff);
    send_pair(15'h7fff, 16'hffff, 15'h7fff, 16'hffff);
    send_pair(15'd27000, 16'd36000, 15'd9000, 0);
    send_pair(15'd9000, 16'd35999, 15'd9000, 0);
    send_pair(15'd18000, 16'd12345, 15'd18000, 16'd22222);
    send_pair(0, 16'd5000, 0, 16'd30000);
    send_pair(15'd3000, 16'd6000, 15'd15000, 16'd24000);
    send_pair(15'h5555, 16'haaaa, 15'h2aaa, 16'h5555);
  endtask

  task automatic test_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_pair(15'($urandom), 16'($urandom), 15'($urandom), 16'($urandom));
      else
        send_pair(15'($urandom_range(0, 18000)), 16'($urandom_range(0, 35999)),
                  15'($urandom_range(0, 18000)), 16'($urandom_range(0, 35999)));
    end
  endtask

  task automatic test_close_pairs(input int n);
    logic [14:0] p;
    logic [15:0] a;
    repeat (n) begin
      p = 15'($urandom_range(0, 18000));
      a = 16'($urandom_range(0, 35999));
      if ($urandom_range(0, 2) == 0) send_pair(p, a, p, a);
      else send_pair(p, a, 15'(p + $urandom_range(0, 3)), 16'(a + $urandom_range(0, 3)));
    end
  endtask

  task automatic test_back_pressure();
    no_gaps = 1'b1;
    hold_cycles = 400;
    test_random(250);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_close_pairs(150);
    no_gaps = 1'b1;
    test_random(150);
    no_gaps = 1'b0;
    test_back_pressure();
    test_random(100);
    pair_valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d direction pairs, checked %0d angles (directed, random, near-identical,",
             pairs_sent, angles_seen);
    $display("back-to-back and long receiver hold-off); %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- opening_angle_from_directions_unit.f -----
rtl/oafd_pkg.sv
rtl/oafd_cordic_cell.sv
rtl/oafd_cordic_chain.sv
rtl/oafd_sqrt_cell.sv
rtl/opening_angle_from_directions_unit.sv
rtl/oafd_checker.sv
tb/opening_angle_from_directions_unit_test.sv
